[hdl/aiffhp_pkg.sv]
// Shared types, codes and helpers for the AIFF header parser.
// No dependencies.
package aiffhp_pkg;

    localparam int AHP_MIN_BUFFER_BYTES = 4096;

    localparam logic [31:0] TAG_FORM  = 32'h4D524F46;
    localparam logic [31:0] TAG_AIFF  = 32'h46464941;
    localparam logic [31:0] TAG_COMM  = 32'h4D4D4F43;
    localparam logic [31:0] TAG_SSND  = 32'h444E5353;
    localparam logic [31:0] COMM_BODY = 32'h12;
    localparam logic [15:0] RATE_BIAS = 16'h400E;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT_BUF = 3'd1;
    localparam logic [2:0] ST_BAD_SIG   = 3'd2;
    localparam logic [2:0] ST_COMM_SHORT = 3'd3;
    localparam logic [2:0] ST_MISSING   = 3'd4;
    localparam logic [2:0] ST_BAD_LEN   = 3'd5;
    localparam logic [2:0] ST_BAD_RATE  = 3'd6;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic        last_byte;
        logic [30:0] buffer_size;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] chan;
        logic [15:0] bits;
        logic [31:0] frames;
        logic [15:0] exponent;
        logic [15:0] mantissa;
        logic [31:0] data_start;
    } t_raw;

    typedef struct packed {
        logic [2:0]  status;
        logic [30:0] sample_rate;
        logic [15:0] channels;
        logic [15:0] bits_per_sample;
        logic [31:0] total_samples;
        logic [14:0] header_length;
        logic [15:0] frame_bytes;
        logic        eight_bit;
    } t_res;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFFFFFF : s[31:0];
    endfunction

    function automatic logic [31:0] padded(input logic [31:0] len);
        logic [32:0] p;
        p = {1'b0, len} + 33'd1;
        p[0] = 1'b0;
        return p[32] ? 32'hFFFFFFFF : p[31:0];
    endfunction

endpackage

[hdl/aiffhp_inq.sv]
// Two-entry input queue that takes byte beats from the stream.
// Depends on aiffhp_pkg.
module aiffhp_inq
    import aiffhp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_beat i_beat,
    output logic     o_full,
    output logic     o_valid,
    output t_in_beat o_beat,
    input  logic     i_take
);
    t_in_beat   r_q [2];
    logic       r_rd;
    logic       r_wr;
    logic [1:0] r_count;
    logic       w_push;
    logic       w_take;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_beat  = r_q[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_take  = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd    <= 1'b0;
            r_wr    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_q[r_wr] <= i_beat;
                r_wr      <= ~r_wr;
            end
            if (w_take) begin
                r_rd <= ~r_rd;
            end
            r_count <= r_count + {1'b0, w_push} - {1'b0, w_take};
        end
    end

    a_inq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2) else $error("input queue overfilled");
    a_inq_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> (r_rd == r_wr)) else $error("pointer skew");
    a_inq_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && !w_push) |=> (r_count == $past(r_count) - 2'd1)) else $error("take lost");
endmodule

[hdl/aiffhp_parse.sv]
// Byte-serial chunk walker: signature, chunk headers, COMM, SSND and skips.
// Depends on aiffhp_pkg.
module aiffhp_parse
    import aiffhp_pkg::*;
#(
    parameter int MIN_BUFFER_BYTES = AHP_MIN_BUFFER_BYTES
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_beat i_beat,
    output logic     o_take,
    input  logic     i_res_full,
    output logic     o_emit,
    output t_raw     o_raw
);
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_SIG  = 3'd1;
    localparam logic [2:0] PH_HDR  = 3'd2;
    localparam logic [2:0] PH_COMM = 3'd3;
    localparam logic [2:0] PH_SSND = 3'd4;
    localparam logic [2:0] PH_SKIP = 3'd5;
    localparam logic [2:0] PH_DONE = 3'd6;

    logic [2:0]  r_phase, n_phase;
    logic [4:0]  r_cnt, n_cnt;
    logic [31:0] r_pos, n_pos, r_fe, n_fe, r_fs, n_fs, r_tag, n_tag;
    logic [31:0] r_len, n_len, r_skip, n_skip, r_ds, n_ds, r_frames, n_frames;
    logic        r_comm, n_comm, r_ssnd, n_ssnd;
    logic [15:0] r_chan, n_chan, r_bits, n_bits, r_exp, n_exp, r_mant, n_mant;

    logic        emit;
    logic [2:0]  est;
    logic        go_next;
    logic        go_skip;
    logic [31:0] skip_amt;
    logic [4:0]  sub;
    logic [7:0]  b;

    assign o_take = i_valid && !i_res_full;
    assign b      = i_beat.data_byte;

    always_comb begin
        n_phase = r_phase; n_cnt = r_cnt; n_pos = r_pos; n_fe = r_fe; n_fs = r_fs;
        n_tag = r_tag; n_len = r_len; n_skip = r_skip; n_ds = r_ds; n_frames = r_frames;
        n_comm = r_comm; n_ssnd = r_ssnd; n_chan = r_chan; n_bits = r_bits;
        n_exp = r_exp; n_mant = r_mant;
        emit = 1'b0; est = ST_OK; go_next = 1'b0; go_skip = 1'b0; skip_amt = '0;
        sub = r_cnt;
        if (o_take) begin
            if (i_beat.first_byte) begin
                n_pos = '0; n_fe = '0; n_fs = '0; n_tag = '0; n_len = '0; n_skip = '0;
                n_ds = '0; n_frames = '0; n_cnt = '0; n_comm = 1'b0; n_ssnd = 1'b0;
                n_chan = '0; n_bits = '0; n_exp = '0; n_mant = '0;
                if (i_beat.buffer_size < 31'(MIN_BUFFER_BYTES)) begin
                    emit = 1'b1; est = ST_SHORT_BUF; n_phase = PH_DONE;
                end else begin
                    n_phase = PH_SIG;
                end
            end
            if (!emit && n_phase != PH_IDLE && n_phase != PH_DONE) begin
                n_pos = sat_add(n_pos, 32'd1);
                sub   = n_cnt;
                if (n_cnt != 5'h1F) n_cnt = n_cnt + 5'd1;
                case (n_phase)
                    PH_SIG: begin
                        if (sub < 5'd4) n_tag = {b, n_tag[31:8]};
                        else if (sub < 5'd8) n_len = {n_len[23:0], b};
                        else n_fs = {b, n_fs[31:8]};
                        if (sub == 5'd11) begin
                            if (n_tag != TAG_FORM || n_fs != TAG_AIFF) begin
                                emit = 1'b1; est = ST_BAD_SIG;
                            end else begin
                                n_fe = sat_add(32'd8, n_len);
                                go_next = 1'b1;
                            end
                        end
                    end
                    PH_HDR: begin
                        if (sub < 5'd4) n_tag = {b, n_tag[31:8]};
                        else n_len = {n_len[23:0], b};
                        if (sub == 5'd7) begin
                            if (n_tag == TAG_COMM && !n_comm) begin
                                if (n_len < COMM_BODY) begin
                                    emit = 1'b1; est = ST_COMM_SHORT;
                                end else begin
                                    n_phase = PH_COMM; n_cnt = '0;
                                end
                            end else if (n_tag == TAG_SSND && !n_ssnd) begin
                                n_phase = PH_SSND; n_cnt = '0; n_fs = '0;
                            end else begin
                                go_skip = 1'b1; skip_amt = padded(n_len);
                            end
                        end
                    end
                    PH_COMM: begin
                        if (sub < 5'd2) n_chan = {n_chan[7:0], b};
                        else if (sub < 5'd6) n_frames = {n_frames[23:0], b};
                        else if (sub < 5'd8) n_bits = {n_bits[7:0], b};
                        else if (sub < 5'd10) n_exp = {n_exp[7:0], b};
                        else if (sub < 5'd12) n_mant = {n_mant[7:0], b};
                        if (sub == 5'(COMM_BODY - 32'd1)) begin
                            n_comm = 1'b1;
                            if (n_ssnd) begin
                                emit = 1'b1; est = ST_OK;
                            end else begin
                                go_skip = 1'b1; skip_amt = padded(n_len) - COMM_BODY;
                            end
                        end
                    end
                    PH_SSND: begin
                        n_fs = {n_fs[23:0], b};
                        if (sub == 5'd3) begin
                            n_ssnd = 1'b1;
                            n_ds   = sat_add(n_pos, n_fs);
                            if (n_comm) begin
                                emit = 1'b1; est = ST_OK;
                            end else begin
                                go_skip  = 1'b1;
                                skip_amt = (padded(n_len) >= 32'd4) ?
                                           padded(n_len) - 32'd4 : 32'd0;
                            end
                        end
                    end
                    PH_SKIP: begin
                        n_skip = r_skip - 32'd1;
                        if (n_skip == 32'd0) go_next = 1'b1;
                    end
                    default: begin
                    end
                endcase
                if (go_skip) begin
                    if (skip_amt == 32'd0) go_next = 1'b1;
                    else begin
                        n_skip = skip_amt; n_phase = PH_SKIP;
                    end
                end
                if (go_next) begin
                    if (n_pos >= n_fe) begin
                        emit = 1'b1; est = ST_MISSING;
                    end else begin
                        n_phase = PH_HDR; n_cnt = '0;
                    end
                end
                if (emit) n_phase = PH_DONE;
                if (!emit && i_beat.last_byte) begin
                    emit = 1'b1;
                    est  = (n_phase == PH_SIG) ? ST_BAD_SIG : ST_MISSING;
                    n_phase = PH_DONE;
                end
            end
        end
    end

    assign o_emit = emit;
    always_comb begin
        o_raw.status     = est;
        o_raw.chan       = n_chan;
        o_raw.bits       = n_bits;
        o_raw.frames     = n_frames;
        o_raw.exponent   = n_exp;
        o_raw.mantissa   = n_mant;
        o_raw.data_start = n_ds;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_cnt <= '0; r_pos <= '0; r_fe <= '0; r_fs <= '0;
            r_tag <= '0; r_len <= '0; r_skip <= '0; r_ds <= '0; r_frames <= '0;
            r_comm <= 1'b0; r_ssnd <= 1'b0; r_chan <= '0; r_bits <= '0;
            r_exp <= '0; r_mant <= '0;
        end else begin
            r_phase <= n_phase; r_cnt <= n_cnt; r_pos <= n_pos; r_fe <= n_fe; r_fs <= n_fs;
            r_tag <= n_tag; r_len <= n_len; r_skip <= n_skip; r_ds <= n_ds;
            r_frames <= n_frames; r_comm <= n_comm; r_ssnd <= n_ssnd; r_chan <= n_chan;
            r_bits <= n_bits; r_exp <= n_exp; r_mant <= n_mant;
        end
    end

    a_emit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |=> (r_phase == PH_DONE)) else $error("result without done");
    a_emit_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |-> o_take) else $error("result without beat");
    a_skip_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SKIP) |-> (r_skip != 32'd0)) else $error("empty skip");
endmodule

[hdl/aiffhp_finish.sv]
// Result stage: data offset and rate checks, frame size, two-entry result queue.
// Depends on aiffhp_pkg.
module aiffhp_finish
    import aiffhp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_raw i_raw,
    output logic o_full,
    output logic o_empty,
    input  logic i_pop,
    output t_res o_res
);
    t_res        r_q [2];
    logic        r_rd;
    logic        r_wr;
    logic [1:0]  r_count;
    t_res        res;
    logic [2:0]  st;
    logic [30:0] rate;
    logic [15:0] shr;
    logic [15:0] shl;
    logic [46:0] wide;
    logic [31:0] prod;
    logic        w_pop;

    always_comb begin
        st   = i_raw.status;
        rate = '0;
        shr  = RATE_BIAS - i_raw.exponent;
        shl  = i_raw.exponent - RATE_BIAS;
        wide = 47'(i_raw.mantissa) << shl[4:0];
        prod = 32'(i_raw.chan) * 32'(i_raw.bits);
        if (st == ST_OK) begin
            if (i_raw.data_start == 32'd0 || i_raw.data_start > 32'd32767) begin
                st = ST_BAD_LEN;
            end else if (i_raw.exponent <= RATE_BIAS) begin
                rate = (shr >= 16'd16) ? 31'd0 : 31'(i_raw.mantissa >> shr[3:0]);
            end else if (i_raw.mantissa != 16'd0) begin
                if (shl >= 16'd31 || wide > 47'h7FFFFFFF) st = ST_BAD_RATE;
                else rate = wide[30:0];
            end
        end
        res = '0;
        res.status = st;
        if (st == ST_OK) begin
            res.sample_rate     = rate;
            res.channels        = i_raw.chan;
            res.bits_per_sample = i_raw.bits;
            res.total_samples   = i_raw.frames;
            res.header_length   = i_raw.data_start[14:0];
            res.frame_bytes     = prod[18:3];
            res.eight_bit       = (i_raw.bits == 16'd8);
        end
    end

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_res   = r_q[r_rd];
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd    <= 1'b0;
            r_wr    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_q[r_wr] <= res;
                r_wr      <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, w_pop};
        end
    end

    a_fin_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full)) else $error("push into full result queue");
    a_fin_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2) else $error("result queue overfilled");
    a_fin_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !w_pop) |=> (r_count == $past(r_count) + 2'd1)) else $error("push lost");
endmodule

[hdl/aiff_header_parser.sv]
// Top level of the AIFF header parser: input queue, chunk walker, result stage.
// Depends on aiffhp_pkg, aiffhp_inq, aiffhp_parse, aiffhp_finish.
//
// Takes one file byte per cycle; each beat is consumed the cycle after it is queued as long as
// the two-entry result queue has room, so the sustained rate is one byte per clock, set by the
// byte-serial chunk walker. A first_byte beat restarts the parse; each buffer yields one result
// (ok or an error status) that is registered into the result queue when its deciding byte is
// taken, and later bytes are dropped until the next first_byte.
module aiff_header_parser
    import aiffhp_pkg::*;
#(
    parameter int MIN_BUFFER_BYTES = AHP_MIN_BUFFER_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    input  logic        i_last_byte,
    input  logic [30:0] i_buffer_size,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_status,
    output logic [30:0] o_sample_rate,
    output logic [15:0] o_channels,
    output logic [15:0] o_bits_per_sample,
    output logic [31:0] o_total_samples,
    output logic [14:0] o_header_length,
    output logic [15:0] o_frame_bytes,
    output logic        o_eight_bit
);
    t_in_beat in_beat;
    t_in_beat q_beat;
    logic     q_valid;
    logic     take;
    logic     res_full;
    logic     emit;
    t_raw     raw;
    t_res     res;

    always_comb begin
        in_beat.data_byte   = i_data_byte;
        in_beat.first_byte  = i_first_byte;
        in_beat.last_byte   = i_last_byte;
        in_beat.buffer_size = i_buffer_size;
    end

    aiffhp_inq u_inq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_beat  (in_beat),
        .o_full  (full),
        .o_valid (q_valid),
        .o_beat  (q_beat),
        .i_take  (take)
    );

    aiffhp_parse #(
        .MIN_BUFFER_BYTES (MIN_BUFFER_BYTES)
    ) u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .i_beat     (q_beat),
        .o_take     (take),
        .i_res_full (res_full),
        .o_emit     (emit),
        .o_raw      (raw)
    );

    aiffhp_finish u_finish (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (emit),
        .i_raw   (raw),
        .o_full  (res_full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_res   (res)
    );

    assign o_status          = res.status;
    assign o_sample_rate     = res.sample_rate;
    assign o_channels        = res.channels;
    assign o_bits_per_sample = res.bits_per_sample;
    assign o_total_samples   = res.total_samples;
    assign o_header_length   = res.header_length;
    assign o_frame_bytes     = res.frame_bytes;
    assign o_eight_bit       = res.eight_bit;
endmodule
